FILE: rtl/core/ntcat_pkg.sv
// ----------------------------------------------------------------------------
// ntcat_pkg: shared constants for the NTC average and table lookup block
// Widths, register indexes, status codes and the thermistor ROM contents.
// ----------------------------------------------------------------------------
`default_nettype none

package ntcat_pkg;

    // sizing
    localparam int AVERAGE_LOG2  = 4;
    localparam int TABLE_ENTRIES = 120;
    localparam int SAMPLE_BITS   = 12;

    localparam int ROM_SIZE     = 120;
    localparam int ROM_AW       = $clog2(ROM_SIZE);
    localparam int ROM_DW       = 10;
    localparam int USED_ENTRIES = (TABLE_ENTRIES < ROM_SIZE) ? TABLE_ENTRIES : ROM_SIZE;
    localparam int IDX_W        = $clog2(USED_ENTRIES);

    localparam int SUM_W  = SAMPLE_BITS + AVERAGE_LOG2;
    localparam int CNT_W  = AVERAGE_LOG2 + 1;
    localparam int AVG_N  = 1 << AVERAGE_LOG2;

    // configuration registers
    localparam int HOLD_W    = 8;
    localparam int LIM_W     = 12;
    localparam int CFG_DW    = 12;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT   = 2'd2;

    localparam logic [HOLD_W-1:0] HOLDOFF_RST = 8'd1;
    localparam logic [LIM_W-1:0]  OPEN_RST    = 12'd900;
    localparam logic [LIM_W-1:0]  SHORT_RST   = 12'd90;

    // compare width covering averages, limits and ROM entries
    localparam int CMP_W = (SAMPLE_BITS > LIM_W) ? SAMPLE_BITS : LIM_W;

    // result fields
    localparam int STATUS_W = 2;
    localparam int TEMP_W   = 11;
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OPEN  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SHORT = 2'd2;

    localparam int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W  = TEMP_W + SAMPLE_BITS;
    localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;

    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] idx;
    } t_srch_rsp;

    // 10K / 3380 NTC divider readings, one entry per degree from -20 C up
    localparam logic [ROM_DW-1:0] ROM_TABLE [ROM_SIZE] = '{
        10'd903, 10'd897, 10'd891, 10'd885, 10'd879, 10'd872, 10'd866, 10'd859,
        10'd852, 10'd845, 10'd838, 10'd830, 10'd822, 10'd815, 10'd807, 10'd798,
        10'd790, 10'd782, 10'd773, 10'd764, 10'd755, 10'd746, 10'd737, 10'd728,
        10'd719, 10'd709, 10'd700, 10'd690, 10'd680, 10'd670, 10'd661, 10'd651,
        10'd641, 10'd631, 10'd621, 10'd611, 10'd601, 10'd591, 10'd581, 10'd571,
        10'd561, 10'd551, 10'd541, 10'd531, 10'd521, 10'd512, 10'd502, 10'd492,
        10'd483, 10'd473, 10'd464, 10'd455, 10'd445, 10'd436, 10'd427, 10'd418,
        10'd410, 10'd401, 10'd393, 10'd384, 10'd376, 10'd368, 10'd360, 10'd352,
        10'd344, 10'd337, 10'd329, 10'd322, 10'd315, 10'd307, 10'd301, 10'd294,
        10'd287, 10'd281, 10'd274, 10'd268, 10'd262, 10'd256, 10'd250, 10'd244,
        10'd238, 10'd233, 10'd228, 10'd222, 10'd217, 10'd212, 10'd207, 10'd202,
        10'd198, 10'd193, 10'd189, 10'd184, 10'd180, 10'd176, 10'd172, 10'd168,
        10'd164, 10'd160, 10'd157, 10'd153, 10'd149, 10'd146, 10'd143, 10'd139,
        10'd136, 10'd133, 10'd130, 10'd127, 10'd124, 10'd122, 10'd119, 10'd116,
        10'd114, 10'd111, 10'd109, 10'd106, 10'd104, 10'd102, 10'd99,  10'd97
    };

endpackage

`default_nettype wire

FILE: rtl/core/ntcat_rom.sv
// ----------------------------------------------------------------------------
// ntcat_rom: thermistor table ROM
// Synchronous read; the data comes from an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ntcat_rom (
    input  wire logic                         i_clk,
    input  wire logic [ntcat_pkg::ROM_AW-1:0] i_addr,
    output logic      [ntcat_pkg::ROM_DW-1:0] o_data
);

    logic [ntcat_pkg::ROM_DW-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (32'(i_addr) < 32'(ntcat_pkg::ROM_SIZE)) begin
            r_data <= ntcat_pkg::ROM_TABLE[i_addr];
        end else begin
            r_data <= '0;
        end
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

FILE: rtl/core/ntcat_search.sv
// ----------------------------------------------------------------------------
// ntcat_search: sequential table search
// Walk the ROM one entry per cycle until value >= entry or the last entry.
// ----------------------------------------------------------------------------
`default_nettype none

module ntcat_search (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic [ntcat_pkg::SAMPLE_BITS-1:0] i_value,
    output ntcat_pkg::t_srch_rsp                   o_rsp
);

    typedef enum logic {
        S_IDLE,
        S_CMP
    } t_state;

    localparam logic [ntcat_pkg::IDX_W-1:0] LAST_IDX =
        ntcat_pkg::IDX_W'(ntcat_pkg::USED_ENTRIES - 1);

    t_state                              r_state, n_state;
    logic [ntcat_pkg::IDX_W-1:0]         r_addr, n_addr;
    logic [ntcat_pkg::SAMPLE_BITS-1:0]   r_value;
    logic [ntcat_pkg::ROM_DW-1:0]        rom_data;
    logic                                hit;

    // ROM is addressed with the next index so its data lines up with r_addr
    ntcat_rom u_rom (
        .i_clk  (i_clk),
        .i_addr (ntcat_pkg::ROM_AW'(n_addr)),
        .o_data (rom_data)
    );

    // Values beyond either end of the table land on the first or last entry
    // here without an explicit clamp.
    assign hit = (ntcat_pkg::CMP_W'(r_value) >= ntcat_pkg::CMP_W'(rom_data))
              || (r_addr == LAST_IDX);

    always_comb begin
        n_state    = r_state;
        n_addr     = r_addr;
        o_rsp.done = 1'b0;
        o_rsp.idx  = r_addr;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_addr  = '0;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (hit) begin
                    o_rsp.done = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_addr <= n_addr;
        if (i_start && r_state == S_IDLE) begin
            r_value <= i_value;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/ntc_average_and_table_lookup.sv
// ----------------------------------------------------------------------------
// ntc_average_and_table_lookup: NTC ADC averaging and temperature lookup
//
// Slave stream takes one transfer per item: tuser = 0 carries an ADC sample
// in tdata, tuser = 1 is a one-second tick. While the hold-off counter is
// zero, samples accumulate; every 16th sample is averaged by a shift and
// checked against the open and short limits. A good average is searched in
// the thermistor ROM, one entry per cycle, and the index times ten goes out
// as the temperature in tenths of a degree above -20 C. Each evaluation
// produces exactly one master transfer; other items produce none.
// A non-evaluating item leaves the slave side ready. An evaluating sample
// holds the slave side until its result enters the output register:
// directly on open or short, else once the ROM search has finished.
// Ticks decrement the hold-off counter, which reloads after each result.
// Reset clears the sum, count, hold-off counter and output valid, and loads
// the register defaults (hold-off 1, open 900, short 90). When the receiver
// stalls, the result holds in the output register; the slave side keeps
// taking items unless a new result is pending behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module ntc_average_and_table_lookup (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // configuration write port
    input  wire logic                                   i_cfg_we,
    input  wire logic [ntcat_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [ntcat_pkg::CFG_DW-1:0]           i_cfg_data,
    // slave stream
    input  wire logic                                   s_axis_tvalid,
    output logic                                        s_axis_tready,
    input  wire logic [ntcat_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // sample, pad
    input  wire logic                                   s_axis_tuser,  // func
    // master stream
    output logic                                        m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    output logic      [ntcat_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,  // temp_code, average, pad
    output logic      [ntcat_pkg::STATUS_W-1:0]         m_axis_tuser   // status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_PEND
    } t_state;

    t_state                              r_state, n_state;

    // configuration
    logic [ntcat_pkg::HOLD_W-1:0]        r_holdoff_reload;
    logic [ntcat_pkg::LIM_W-1:0]         r_open_limit;
    logic [ntcat_pkg::LIM_W-1:0]         r_short_limit;

    // accumulation state
    logic [ntcat_pkg::SUM_W-1:0]         r_sum, n_sum;
    logic [ntcat_pkg::CNT_W-1:0]         r_count, n_count;
    logic [ntcat_pkg::HOLD_W-1:0]        r_holdoff, n_holdoff;

    // pending result
    logic [ntcat_pkg::STATUS_W-1:0]      r_res_status, n_res_status;
    logic [ntcat_pkg::TEMP_W-1:0]        r_res_temp, n_res_temp;
    logic [ntcat_pkg::SAMPLE_BITS-1:0]   r_res_avg, n_res_avg;

    // output register
    logic                                r_out_valid, n_out_valid;
    logic [ntcat_pkg::STATUS_W-1:0]      r_out_status;
    logic [ntcat_pkg::TEMP_W-1:0]        r_out_temp;
    logic [ntcat_pkg::SAMPLE_BITS-1:0]   r_out_avg;

    logic                                in_xfer;
    logic                                take_sample;
    logic                                last_sample;
    logic [ntcat_pkg::SUM_W-1:0]         sum_add;
    logic [ntcat_pkg::SAMPLE_BITS-1:0]   avg;
    logic                                is_open;
    logic                                is_short;
    logic                                srch_start;
    ntcat_pkg::t_srch_rsp                srch_rsp;
    logic                                out_load;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign take_sample   = in_xfer && !s_axis_tuser && (r_holdoff == '0);
    assign last_sample   = (r_count == ntcat_pkg::CNT_W'(ntcat_pkg::AVG_N - 1));
    assign sum_add       = r_sum
                         + ntcat_pkg::SUM_W'(s_axis_tdata[ntcat_pkg::SAMPLE_BITS-1:0]);
    assign avg           = sum_add[ntcat_pkg::SUM_W-1:ntcat_pkg::AVERAGE_LOG2];
    assign is_open       = ntcat_pkg::CMP_W'(avg) > ntcat_pkg::CMP_W'(r_open_limit);
    assign is_short      = ntcat_pkg::CMP_W'(avg) < ntcat_pkg::CMP_W'(r_short_limit);
    assign srch_start    = take_sample && last_sample && !is_open && !is_short;
    assign out_load      = (r_state == S_PEND) && (!r_out_valid || m_axis_tready);

    ntcat_search u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (srch_start),
        .i_value (avg),
        .o_rsp   (srch_rsp)
    );

    always_comb begin
        n_state      = r_state;
        n_sum        = r_sum;
        n_count      = r_count;
        n_holdoff    = r_holdoff;
        n_res_status = r_res_status;
        n_res_temp   = r_res_temp;
        n_res_avg    = r_res_avg;
        n_out_valid  = r_out_valid;

        if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        if (out_load) begin
            n_out_valid = 1'b1;
            n_state     = S_IDLE;
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer && s_axis_tuser && (r_holdoff != '0)) begin
                    n_holdoff = r_holdoff - 1'b1;
                end
                if (take_sample) begin
                    if (last_sample) begin
                        // evaluate: clear the accumulator and start hold-off
                        n_sum     = '0;
                        n_count   = '0;
                        n_holdoff = r_holdoff_reload;
                        n_res_avg = avg;
                        n_res_temp = '0;
                        if (is_open) begin
                            n_res_status = ntcat_pkg::ST_OPEN;
                            n_state      = S_PEND;
                        end else if (is_short) begin
                            n_res_status = ntcat_pkg::ST_SHORT;
                            n_state      = S_PEND;
                        end else begin
                            n_res_status = ntcat_pkg::ST_OK;
                            n_state      = S_SEARCH;
                        end
                    end else begin
                        n_sum   = sum_add;
                        n_count = r_count + 1'b1;
                    end
                end
            end
            S_SEARCH: begin
                if (srch_rsp.done) begin
                    // index times ten as two shifts
                    n_res_temp = (ntcat_pkg::TEMP_W'(srch_rsp.idx) << 3)
                               + (ntcat_pkg::TEMP_W'(srch_rsp.idx) << 1);
                    n_state    = S_PEND;
                end
            end
            S_PEND: begin
                // hold until the output register frees up
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_holdoff_reload <= ntcat_pkg::HOLDOFF_RST;
            r_open_limit     <= ntcat_pkg::OPEN_RST;
            r_short_limit    <= ntcat_pkg::SHORT_RST;
            r_sum            <= '0;
            r_count          <= '0;
            r_holdoff        <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_count     <= n_count;
            r_holdoff   <= n_holdoff;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ntcat_pkg::CFG_HOLDOFF:
                        r_holdoff_reload <= i_cfg_data[ntcat_pkg::HOLD_W-1:0];
                    ntcat_pkg::CFG_OPEN:
                        r_open_limit <= i_cfg_data[ntcat_pkg::LIM_W-1:0];
                    ntcat_pkg::CFG_SHORT:
                        r_short_limit <= i_cfg_data[ntcat_pkg::LIM_W-1:0];
                    default: begin
                        // drop writes to unused indexes
                    end
                endcase
            end
        end
        r_res_status <= n_res_status;
        r_res_temp   <= n_res_temp;
        r_res_avg    <= n_res_avg;
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_temp   <= r_res_temp;
            r_out_avg    <= r_res_avg;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = ntcat_pkg::OUT_TDATA_W'({r_out_avg, r_out_temp});

endmodule

`default_nettype wire

FILE: rtl/core/ntcat_checker.sv
// ----------------------------------------------------------------------------
// ntcat_checker: port-level checks for the NTC lookup block
// Watches the master stream and reset behavior; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ntcat_checker (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    input  wire logic [ntcat_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    input  wire logic [ntcat_pkg::STATUS_W-1:0]         m_axis_tuser
);

    localparam logic [ntcat_pkg::TEMP_W-1:0] TEMP_MAX =
        ntcat_pkg::TEMP_W'((ntcat_pkg::USED_ENTRIES - 1) * 10);

    logic [ntcat_pkg::TEMP_W-1:0] temp;
    assign temp = m_axis_tdata[ntcat_pkg::TEMP_W-1:0];

    // stalled result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // a fault status never carries a temperature
    a_fault_temp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != ntcat_pkg::ST_OK) |-> temp == '0)
        else $error("fault status with nonzero temperature");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == ntcat_pkg::ST_OK)
                       || (m_axis_tuser == ntcat_pkg::ST_OPEN)
                       || (m_axis_tuser == ntcat_pkg::ST_SHORT))
        else $error("undefined status code");

    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> temp <= TEMP_MAX)
        else $error("temperature beyond table range");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind ntc_average_and_table_lookup ntcat_checker u_ntcat_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for ntc_average_and_table_lookup
// Drives ADC samples and one-second ticks into the slave stream, with random
// gaps and receiver stalls. Each accepted transfer goes through a predictor
// of the averaging, limit checks and thermistor table search. Every result on
// the master stream is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb;

    // item kinds carried on s_axis_tuser
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    // longest evaluation (ROM search over every entry) plus some margin
    localparam int SETTLE_CYCLES = 130;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int REPORT_MAX    = 10;

    typedef struct packed {
        logic [ntcat_pkg::STATUS_W-1:0]    status;
        logic [ntcat_pkg::TEMP_W-1:0]      temp_code;
        logic [ntcat_pkg::SAMPLE_BITS-1:0] average;
    } t_reading;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_cfg_we;
    logic [ntcat_pkg::CFG_IDX_W-1:0]     i_cfg_idx;
    logic [ntcat_pkg::CFG_DW-1:0]        i_cfg_data;
    logic                                s_axis_tvalid;
    logic                                s_axis_tready;
    logic [ntcat_pkg::IN_TDATA_W-1:0]    s_axis_tdata;   // sample, pad
    logic                                s_axis_tuser;   // func
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic [ntcat_pkg::OUT_TDATA_W-1:0]   m_axis_tdata;   // temp_code, average, pad
    logic [ntcat_pkg::STATUS_W-1:0]      m_axis_tuser;   // status

    // predictor copy of the registers and the averaging state
    logic [ntcat_pkg::HOLD_W-1:0]        cfg_holdoff;
    logic [ntcat_pkg::LIM_W-1:0]         cfg_open;
    logic [ntcat_pkg::LIM_W-1:0]         cfg_short;
    logic [ntcat_pkg::SUM_W-1:0]         acc_sum;
    logic [ntcat_pkg::CNT_W-1:0]         acc_count;
    logic [ntcat_pkg::HOLD_W-1:0]        holdoff_left;

    t_reading                 expected_readings[$];
    int                       mismatch_count;
    int                       cycle_count;
    bit                       tx_burst;
    bit                       rx_burst;
    int                       stall_left;

    ntc_average_and_table_lookup dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Clamp the average into the table span, then take the first entry that
    // the value reaches from above; the last entry catches everything else.
    function automatic logic [ntcat_pkg::TEMP_W-1:0] table_temp_code(
        input logic [ntcat_pkg::SAMPLE_BITS-1:0] avg);
        int last;
        int idx;
        int v;
        last = ntcat_pkg::USED_ENTRIES - 1;
        v    = avg;
        if (v > ntcat_pkg::ROM_TABLE[0]) v = ntcat_pkg::ROM_TABLE[0];
        if (v < ntcat_pkg::ROM_TABLE[last]) v = ntcat_pkg::ROM_TABLE[last];
        idx = 0;
        while (idx < last && v < ntcat_pkg::ROM_TABLE[idx]) idx++;
        return ntcat_pkg::TEMP_W'(idx * 10);
    endfunction

    // Advance the predictor by one accepted transfer; queue a reading when
    // the transfer completes an averaging run.
    task automatic predict_accept(input logic func,
                                  input logic [ntcat_pkg::SAMPLE_BITS-1:0] smp);
        t_reading                           r;
        logic [ntcat_pkg::SAMPLE_BITS-1:0]  avg;
        if (func == FUNC_TICK) begin
            if (holdoff_left != 0) holdoff_left = holdoff_left - 1'b1;
        end else if (holdoff_left == 0) begin
            acc_sum   = acc_sum + ntcat_pkg::SUM_W'(smp);
            acc_count = acc_count + 1'b1;
            if (acc_count == ntcat_pkg::CNT_W'(ntcat_pkg::AVG_N)) begin
                avg = acc_sum[ntcat_pkg::SUM_W-1:ntcat_pkg::AVERAGE_LOG2];
                if (avg > cfg_open) begin
                    r.status    = ntcat_pkg::ST_OPEN;
                    r.temp_code = '0;
                end else if (avg < cfg_short) begin
                    r.status    = ntcat_pkg::ST_SHORT;
                    r.temp_code = '0;
                end else begin
                    r.status    = ntcat_pkg::ST_OK;
                    r.temp_code = table_temp_code(avg);
                end
                r.average = avg;
                expected_readings.push_back(r);
                acc_sum      = '0;
                acc_count    = '0;
                holdoff_left = cfg_holdoff;
            end
        end
    endtask

    // Mostly back-to-back, sometimes a short gap, now and then a long one.
    function automatic int pick_gap();
        int r;
        if ($urandom_range(0, 49) == 0) tx_burst = ~tx_burst;
        if (tx_burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Present one item and hold it until the slave side takes the transfer.
    task automatic send_item(input logic func, input logic [ntcat_pkg::SAMPLE_BITS-1:0] smp);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {{(ntcat_pkg::IN_TDATA_W - ntcat_pkg::SAMPLE_BITS){1'b0}}, smp};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_accept(func, smp);
    endtask

    // Drop valid, let every predicted reading arrive, then give the block
    // time to finish any ROM search before the caller touches registers.
    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all three registers on consecutive edges; the block is idle.
    task automatic write_config(input logic [ntcat_pkg::HOLD_W-1:0] hold,
                                input logic [ntcat_pkg::LIM_W-1:0] open_lim,
                                input logic [ntcat_pkg::LIM_W-1:0] short_lim);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= ntcat_pkg::CFG_HOLDOFF;
        i_cfg_data <= ntcat_pkg::CFG_DW'(hold);
        @(posedge i_clk);
        cfg_holdoff = hold;
        i_cfg_idx  <= ntcat_pkg::CFG_OPEN;
        i_cfg_data <= ntcat_pkg::CFG_DW'(open_lim);
        @(posedge i_clk);
        cfg_open = open_lim;
        i_cfg_idx  <= ntcat_pkg::CFG_SHORT;
        i_cfg_data <= ntcat_pkg::CFG_DW'(short_lim);
        @(posedge i_clk);
        cfg_short = short_lim;
        i_cfg_we   <= 1'b0;
    endtask

    function automatic int clamp_sample(input int v);
        if (v < 0) return 0;
        if (v > 4095) return 4095;
        return v;
    endfunction

    // Target average: spread over the whole range, near the limits, near the
    // table ends, and inside the table span most of the time.
    function automatic int pick_average_target();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return $urandom_range(0, 4095);
        if (r < 28) return clamp_sample(int'(cfg_open) + $urandom_range(0, 4) - 2);
        if (r < 41) return clamp_sample(int'(cfg_short) + $urandom_range(0, 4) - 2);
        if (r < 50) return ($urandom_range(0, 1) != 0) ? $urandom_range(94, 100)
                                                      : $urandom_range(900, 906);
        return $urandom_range(97, 903);
    endfunction

    // Sixteen samples whose sum lands on the target average plus a random
    // remainder; the spread decides how far single samples wander.
    task automatic send_averaging_run(input int target, input int spread);
        int total;
        int so_far;
        int v;
        total  = target * ntcat_pkg::AVG_N + $urandom_range(0, ntcat_pkg::AVG_N - 1);
        so_far = 0;
        for (int k = 0; k < ntcat_pkg::AVG_N - 1; k++) begin
            v = clamp_sample(target + $urandom_range(0, 2 * spread) - spread);
            so_far += v;
            send_item(FUNC_SAMPLE, ntcat_pkg::SAMPLE_BITS'(v));
            // ticks with the counter at zero change nothing
            if ($urandom_range(0, 19) == 0)
                send_item(FUNC_TICK, ntcat_pkg::SAMPLE_BITS'($urandom));
        end
        send_item(FUNC_SAMPLE, ntcat_pkg::SAMPLE_BITS'(clamp_sample(total - so_far)));
    endtask

    // Tick the hold-off away, with samples mixed in that must be dropped.
    task automatic wait_out_holdoff();
        while (holdoff_left != 0) begin
            if ($urandom_range(0, 4) == 0)
                send_item(FUNC_SAMPLE, ntcat_pkg::SAMPLE_BITS'($urandom_range(0, 4095)));
            send_item(FUNC_TICK, ntcat_pkg::SAMPLE_BITS'($urandom));
        end
    endtask

    function automatic int pick_spread();
        int r;
        r = $urandom_range(0, 3);
        if (r == 0) return 0;
        if (r == 1) return 8;
        if (r == 2) return 300;
        return 4095;
    endfunction

    // Reset defaults, tick at zero, full-scale samples, sample in hold-off.
    task automatic test_directed_items();
        send_item(FUNC_TICK, 12'hFFF);
        for (int k = 0; k < ntcat_pkg::AVG_N; k++)
            send_item(FUNC_SAMPLE, (k % 2 == 0) ? 12'hFFF : 12'h000);
        send_item(FUNC_SAMPLE, 12'hFFF);
        send_item(FUNC_TICK, 12'h000);
        send_item(FUNC_TICK, 12'hA5A);
        settle_block();
    endtask

    // Limits wide open: every average goes through the table search.
    task automatic test_lookup_sweep();
        write_config(8'd0, 12'd4095, 12'd0);
        for (int k = 0; k < 40; k++) begin
            send_averaging_run(pick_average_target(), pick_spread());
            wait_out_holdoff();
        end
        settle_block();
    endtask

    // Open and short checks at the table ends and at random limits.
    task automatic test_limit_checks();
        for (int p = 0; p < 3; p++) begin
            if (p == 0) write_config(8'd0, 12'd903, 12'd97);
            else write_config(ntcat_pkg::HOLD_W'($urandom_range(1, 4)),
                              ntcat_pkg::LIM_W'($urandom_range(0, 4095)),
                              ntcat_pkg::LIM_W'($urandom_range(0, 1200)));
            for (int k = 0; k < 6; k++) begin
                send_averaging_run(pick_average_target(), pick_spread());
                wait_out_holdoff();
            end
            settle_block();
        end
    endtask

    // Longest hold-off with both limits at their extremes.
    task automatic test_holdoff_extremes();
        write_config(8'd255, 12'd0, 12'd4095);
        send_averaging_run(0, 0);
        wait_out_holdoff();
        send_averaging_run(4095, 0);
        wait_out_holdoff();
        settle_block();
    endtask

    // Unstructured traffic back at the default register values.
    task automatic test_random_traffic();
        write_config(ntcat_pkg::HOLDOFF_RST, ntcat_pkg::OPEN_RST, ntcat_pkg::SHORT_RST);
        for (int k = 0; k < 200; k++) begin
            if ($urandom_range(0, 9) < 3)
                send_item(FUNC_TICK, ntcat_pkg::SAMPLE_BITS'($urandom));
            else if ($urandom_range(0, 1) != 0)
                send_item(FUNC_SAMPLE, ntcat_pkg::SAMPLE_BITS'($urandom_range(0, 1023)));
            else
                send_item(FUNC_SAMPLE, ntcat_pkg::SAMPLE_BITS'($urandom_range(0, 4095)));
        end
        settle_block();
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= ntcat_pkg::CFG_HOLDOFF;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= FUNC_SAMPLE;
        cfg_holdoff    = ntcat_pkg::HOLDOFF_RST;
        cfg_open       = ntcat_pkg::OPEN_RST;
        cfg_short      = ntcat_pkg::SHORT_RST;
        acc_sum        = '0;
        acc_count      = '0;
        holdoff_left   = '0;
        mismatch_count = 0;
        tx_burst       = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_items();
        test_lookup_sweep();
        test_limit_checks();
        test_holdoff_extremes();
        test_random_traffic();

        if (mismatch_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    // Result checker and receiver stall generator. Compare each master
    // transfer with the oldest prediction, then pick the next ready value.
    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_readings.size() == 0) begin
                if (mismatch_count < REPORT_MAX)
                    $display("unexpected result: status %0d temp %0d avg %0d",
                             m_axis_tuser, m_axis_tdata[ntcat_pkg::TEMP_W-1:0],
                             m_axis_tdata[ntcat_pkg::TEMP_W +: ntcat_pkg::SAMPLE_BITS]);
                mismatch_count++;
            end else begin
                want = expected_readings.pop_front();
                if (m_axis_tuser !== want.status
                    || m_axis_tdata[ntcat_pkg::TEMP_W-1:0] !== want.temp_code
                    || m_axis_tdata[ntcat_pkg::TEMP_W +: ntcat_pkg::SAMPLE_BITS]
                       !== want.average) begin
                    if (mismatch_count < REPORT_MAX)
                        $display({"mismatch: expected status %0d temp %0d avg %0d, ",
                                  "got status %0d temp %0d avg %0d"},
                                 want.status, want.temp_code, want.average, m_axis_tuser,
                                 m_axis_tdata[ntcat_pkg::TEMP_W-1:0],
                                 m_axis_tdata[ntcat_pkg::TEMP_W +: ntcat_pkg::SAMPLE_BITS]);
                    mismatch_count++;
                end
            end
        end
        if ($urandom_range(0, 63) == 0) rx_burst <= ~rx_burst;
        if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if (!rx_burst && $urandom_range(0, 99) < 25) begin
            m_axis_tready <= 1'b0;
            stall_left    <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                        : $urandom_range(5, 40);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    initial begin
        rx_burst    = 1'b0;
        stall_left  = 0;
        cycle_count = 0;
    end

    // Watchdog: end the run once the cycle count reaches CYCLE_LIMIT.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

endmodule

`default_nettype wire
